### sv/ssj_pkg.sv
// Shared types, constants and lookup functions of the status record JSON serializer.
package ssj_pkg;

	localparam int RECORDS_PER_FRAME_DEF = 7;

	// Key names, right-aligned in 14 character slots, and their lengths.
	localparam int KeyMaxLen = 14;
	localparam logic [KeyMaxLen*8-1:0] KEY_TEXT [8] = '{
		"0z0", "\"TEMP\"", "\"HUMEDITY\"", "\"BATT\"",
		"\"SPEED\"", "\"DISPLACEMENT\"", "\"HEIGHT\"", "\"GEOPOS\""
	};
	localparam logic [3:0] KEY_LEN [8] = '{
		4'd3, 4'd6, 4'd10, 4'd6, 4'd7, 4'd14, 4'd8, 4'd8
	};

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_Z     = 8'h7A;

	// Index of the last decimal digit (units).
	localparam logic [2:0] DIG_UNITS = 3'd4;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_ERR,
		PH_PRE0,
		PH_PRE1,
		PH_KEY,
		PH_COLON,
		PH_DIGIT,
		PH_OPEN,
		PH_CL0,
		PH_CL1,
		PH_CL2
	} phase_t;

	// One unit of text work handed from the frame parser to the emitter.
	typedef struct packed {
		logic        err;        // lead with an error item
		logic        rec;        // emit a record
		logic        first;      // record opens the object rather than following one
		logic        close;      // frame ends after this record
		logic        open;       // closing needs an opening brace first
		logic [2:0]  key;
		logic [2:0]  dig_start;  // first printed decimal digit
		logic [15:0] value;
	} job_t;

	function automatic logic [7:0] hdr_char(logic [1:0] idx);
		case (idx)
			2'd1:    return CH_Z;
			default: return CH_ZERO;
		endcase
	endfunction

	function automatic logic [7:0] key_char(logic [2:0] k, logic [3:0] p);
		logic [KeyMaxLen*8-1:0] t;
		logic [3:0]             r;
		t = KEY_TEXT[k];
		r = KEY_LEN[k] - 4'd1 - p;
		return t[{r, 3'b000} +: 8];
	endfunction

	function automatic logic [16:0] pow10(logic [2:0] d);
		case (d)
			3'd0:    return 17'd10000;
			3'd1:    return 17'd1000;
			3'd2:    return 17'd100;
			3'd3:    return 17'd10;
			default: return 17'd1;
		endcase
	endfunction

endpackage

### sv/ssj_parser.sv
// Frame parser: tracks header and record bytes and builds the text job for each record.
module ssj_parser import ssj_pkg::*; #(
	parameter int RECORDS_PER_FRAME = RECORDS_PER_FRAME_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] in_byte,
	output logic       job_valid,
	output job_t       job
);

	localparam int PosW = $clog2(RECORDS_PER_FRAME + 1);

	localparam logic [1:0] BP_KEY  = 2'd0;
	localparam logic [1:0] BP_HIGH = 2'd1;
	localparam logic [1:0] BP_LOW  = 2'd2;

	logic [PosW-1:0] pos_q;
	logic [1:0]      phase_q;
	logic            header_good_q;
	logic [7:0]      held_key_q;
	logic [7:0]      held_high_q;
	logic            emitted_q;

	logic        hg_hdr;
	logic        key_bad;
	logic        last_rec;
	logic        emitted_new;
	logic [15:0] value;

	always_comb begin
		hg_hdr      = header_good_q & (in_byte == hdr_char(phase_q));
		key_bad     = |held_key_q[7:3];
		last_rec    = pos_q >= PosW'(RECORDS_PER_FRAME);
		value       = {held_high_q, in_byte};
		emitted_new = emitted_q | (header_good_q & ~key_bad);

		job           = '0;
		job.key       = held_key_q[2:0];
		job.value     = value;
		job.first     = ~emitted_q;
		job.close     = last_rec;
		job.open      = ~emitted_new;
		job.err       = key_bad;
		job.rec       = ~key_bad;
		if (value >= 16'd10000)
			job.dig_start = 3'd0;
		else if (value >= 16'd1000)
			job.dig_start = 3'd1;
		else if (value >= 16'd100)
			job.dig_start = 3'd2;
		else if (value >= 16'd10)
			job.dig_start = 3'd3;
		else
			job.dig_start = DIG_UNITS;

		job_valid = 1'b0;
		if (pos_q == '0) begin
			// Bad header: a lone error item, nothing else.
			job_valid = (phase_q == BP_LOW) & ~hg_hdr;
			job.err   = 1'b1;
			job.rec   = 1'b0;
			job.close = 1'b0;
		end else if (phase_q == BP_LOW) begin
			job_valid = header_good_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= '0;
			phase_q       <= BP_KEY;
			header_good_q <= 1'b1;
			held_key_q    <= '0;
			held_high_q   <= '0;
			emitted_q     <= 1'b0;
		end else if (accept) begin
			if (pos_q == '0) begin
				header_good_q <= hg_hdr;
				if (phase_q == BP_LOW) begin
					phase_q <= BP_KEY;
					pos_q   <= PosW'(1);
				end else begin
					phase_q <= phase_q + 2'd1;
				end
			end else begin
				case (phase_q)
					BP_KEY: begin
						held_key_q <= in_byte;
						phase_q    <= BP_HIGH;
					end
					BP_HIGH: begin
						held_high_q <= in_byte;
						phase_q     <= BP_LOW;
					end
					default: begin
						phase_q <= BP_KEY;
						if (last_rec) begin
							pos_q         <= '0;
							header_good_q <= 1'b1;
							emitted_q     <= 1'b0;
						end else begin
							pos_q     <= pos_q + PosW'(1);
							emitted_q <= emitted_new;
						end
					end
				endcase
			end
		end
	end

endmodule

### sv/ssj_emitter.sv
// Text emitter: walks one job character by character into the output register.
module ssj_emitter import ssj_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       job_load,
	input  job_t       job,
	output logic       can_take,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic       is_error,
	output logic       run_last,
	output logic       text_done
);

	phase_t      phase_q, phase_d, phase_nxt, phase_start;
	job_t        job_q;
	logic [3:0]  pos_q;
	logic [2:0]  dig_q;
	logic [15:0] rem_q;

	logic       ov_q, err_q, last_q, done_q;
	logic [7:0] char_q;

	logic        busy, step, out_load;
	logic [7:0]  ch;
	logic        ch_err, ch_last, ch_done;
	logic [3:0]  digit;
	logic [16:0] sub;
	logic [16:0] thr;

	// Current decimal digit: count of multiples of the place value that fit.
	always_comb begin
		digit = 4'd0;
		sub   = '0;
		for (int j = 1; j <= 9; j++) begin
			thr = pow10(dig_q) * 17'(j);
			if ({1'b0, rem_q} >= thr) begin
				digit = 4'(j);
				sub   = thr;
			end
		end
	end

	always_comb begin
		busy     = phase_q != PH_IDLE;
		out_load = ~ov_q | out_ready;
		step     = busy & out_load;

		ch        = CH_NUL;
		ch_err    = 1'b0;
		ch_last   = 1'b0;
		ch_done   = 1'b0;
		phase_nxt = PH_IDLE;
		case (phase_q)
			PH_ERR: begin
				ch_err    = 1'b1;
				ch_last   = ~job_q.close;
				phase_nxt = job_q.close ? (job_q.open ? PH_OPEN : PH_CL0) : PH_IDLE;
			end
			PH_PRE0: begin
				ch        = job_q.first ? CH_LBRACE : CH_COMMA;
				phase_nxt = PH_PRE1;
			end
			PH_PRE1: begin
				ch        = CH_LF;
				phase_nxt = PH_KEY;
			end
			PH_KEY: begin
				ch        = key_char(job_q.key, pos_q);
				phase_nxt = (pos_q == KEY_LEN[job_q.key] - 4'd1) ? PH_COLON : PH_KEY;
			end
			PH_COLON: begin
				ch        = CH_COLON;
				phase_nxt = PH_DIGIT;
			end
			PH_DIGIT: begin
				ch        = CH_ZERO + {4'd0, digit};
				ch_last   = (dig_q == DIG_UNITS) & ~job_q.close;
				phase_nxt = (dig_q != DIG_UNITS) ? PH_DIGIT
				          : (job_q.close ? PH_CL0 : PH_IDLE);
			end
			PH_OPEN: begin
				ch        = CH_LBRACE;
				phase_nxt = PH_CL0;
			end
			PH_CL0: begin
				ch        = CH_LF;
				phase_nxt = PH_CL1;
			end
			PH_CL1: begin
				ch        = CH_RBRACE;
				phase_nxt = PH_CL2;
			end
			PH_CL2: begin
				ch        = CH_LF;
				ch_last   = 1'b1;
				ch_done   = 1'b1;
				phase_nxt = PH_IDLE;
			end
			default: begin
				phase_nxt = PH_IDLE;
			end
		endcase

		can_take = ~busy | (step & ch_last);

		if (job.err)
			phase_start = PH_ERR;
		else if (job.rec)
			phase_start = PH_PRE0;
		else if (job.open)
			phase_start = PH_OPEN;
		else
			phase_start = PH_CL0;

		if (job_load)
			phase_d = phase_start;
		else if (step)
			phase_d = phase_nxt;
		else
			phase_d = phase_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			phase_q <= PH_IDLE;
		else
			phase_q <= phase_d;
	end

	always_ff @(posedge clk) begin
		if (job_load) begin
			job_q <= job;
			pos_q <= '0;
			dig_q <= job.dig_start;
			rem_q <= job.value;
		end else if (step) begin
			if (phase_q == PH_KEY)
				pos_q <= pos_q + 4'd1;
			if (phase_q == PH_DIGIT) begin
				dig_q <= dig_q + 3'd1;
				rem_q <= 16'({1'b0, rem_q} - sub);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ov_q <= 1'b0;
		else if (out_load)
			ov_q <= busy;
	end

	always_ff @(posedge clk) begin
		if (step) begin
			char_q <= ch;
			err_q  <= ch_err;
			last_q <= ch_last;
			done_q <= ch_done;
		end
	end

	assign out_valid = ov_q;
	assign out_char  = char_q;
	assign is_error  = err_q;
	assign run_last  = last_q;
	assign text_done = done_q;

endmodule

### sv/status_record_json_serializer.sv
// An accepted item loads the emitter phase and job registers; its first character is
// then registered in the single output register. An item that causes no text does not
// hold the emitter; one that causes k characters (at most 25) gives one character per
// cycle while the consumer is ready; the next item is taken as the last one is loaded.
// Reset: arst_n clears frame tracking, the emitter phase and the output valid at once.
module status_record_json_serializer import ssj_pkg::*; #(
	parameter int RECORDS_PER_FRAME = RECORDS_PER_FRAME_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic       is_error,
	output logic       run_last,
	output logic       text_done
);

	// An item is taken whenever the emitter is free or is handing over the final
	// character of its current job, so the parser and emitter overlap.
	logic accept;
	logic job_valid;
	job_t job;

	assign accept = in_valid & in_ready;

	// The parser follows header and record bytes and, on the third byte of a
	// record (or of a bad header), describes the text to be produced.
	ssj_parser #(
		.RECORDS_PER_FRAME(RECORDS_PER_FRAME)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.in_byte  (in_byte),
		.job_valid(job_valid),
		.job      (job)
	);

	// The emitter turns the job into characters, one per cycle while the consumer is ready,
	// behind an output register, so a stalled consumer blocks the parser only while busy.
	ssj_emitter u_emitter (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_load (accept & job_valid),
		.job      (job),
		.can_take (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_char (out_char),
		.is_error (is_error),
		.run_last (run_last),
		.text_done(text_done)
	);

	// The closing newline always ends the run of its item.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && text_done |-> run_last && !is_error)
		else $error("closing newline not marked as end of run");

	// Error items carry no character, and text items never carry a zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_error == (out_char == 8'd0)))
		else $error("error flag and character disagree");

	// A waiting result stays on offer until the consumer takes it.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

endmodule
